[hw/rtl/alcs_pkg.sv]
// Shared types and constants for the auto-levels contrast stretch block.
// Used by alcs_front, alcs_queue, alcs_back and the top level; no dependencies.
package alcs_pkg;

  localparam int PixW          = 8;
  localparam int NumChan       = 3;
  localparam int LimitW        = 9;
  localparam int GrayAccW      = 13;
  localparam int NumW          = 2 * PixW;
  localparam int DivSteps      = PixW;
  localparam int StepCntW      = $clog2(DivSteps);
  localparam int CfgAddrW      = 2;
  localparam int CfgDataW      = 32;
  localparam int QueueDepthDef = 4;

  localparam logic [PixW-1:0]     MaxLevel   = 8'd255;
  localparam logic [PixW-1:0]     MinLevel   = 8'd0;
  localparam logic [LimitW-1:0]   LimitReset = 9'd100;
  localparam logic [CfgAddrW-1:0] RegLimitAddr = 2'd0;

  // channel lanes: red, green, blue
  localparam int ChRed   = 0;
  localparam int ChGreen = 1;
  localparam int ChBlue  = 2;

  typedef enum logic {
    CMD_MEASURE = 1'b0,
    CMD_APPLY   = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } back_state_t;

  typedef struct packed {
    logic                             armed;
    logic [PixW-1:0]                  lo;
    logic [PixW-1:0]                  range;
    logic [NumChan-1:0][PixW-1:0]     rgb;
    logic [PixW-1:0]                  alpha;
  } entry_t;

  typedef struct packed {
    logic [NumChan-1:0][PixW-1:0]     rgb;
    logic [PixW-1:0]                  alpha;
    logic                             stretched;
  } result_t;

endpackage

[hw/rtl/auto_levels_contrast_stretch.sv]
// Auto-levels contrast stretch. Measure pixels are taken one per clock while
// the queue has room. An apply pixel goes through the queue and, when
// stretching is on, the 8-step divider before it reaches the result ports;
// the back end takes a new pixel only after the last one is registered out.
// Synchronous active-low reset empties the queue and result register,
// restores the trackers, disarms stretching and sets the limit to 100.
module auto_levels_contrast_stretch #(
  parameter int QueueDepth = alcs_pkg::QueueDepthDef
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic                            in_command,
  input  logic [alcs_pkg::PixW-1:0]       in_red_in,
  input  logic [alcs_pkg::PixW-1:0]       in_green_in,
  input  logic [alcs_pkg::PixW-1:0]       in_blue_in,
  input  logic [alcs_pkg::PixW-1:0]       in_alpha_in,
  input  logic                            in_frame_end,
  output logic                            empty,
  input  logic                            pop,
  output logic [alcs_pkg::PixW-1:0]       out_red_out,
  output logic [alcs_pkg::PixW-1:0]       out_green_out,
  output logic [alcs_pkg::PixW-1:0]       out_blue_out,
  output logic [alcs_pkg::PixW-1:0]       out_alpha_out,
  output logic                            out_was_stretched,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [alcs_pkg::CfgAddrW-1:0]   paddr,
  input  logic [alcs_pkg::CfgDataW-1:0]   pwdata,
  output logic [alcs_pkg::CfgDataW-1:0]   prdata,
  output logic                            pready
);

  logic [alcs_pkg::LimitW-1:0] limit_r, limit_nxt;
  logic                        cfg_wr;
  logic                        q_push, q_pop, q_full, q_empty;
  alcs_pkg::entry_t            q_wr_data, q_rd_data;
  alcs_pkg::result_t           res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    limit_nxt = limit_r;
    if (cfg_wr && paddr == alcs_pkg::RegLimitAddr) begin
      limit_nxt = pwdata[alcs_pkg::LimitW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= alcs_pkg::LimitReset;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  assign prdata = (paddr == alcs_pkg::RegLimitAddr) ?
                  alcs_pkg::CfgDataW'(limit_r) : '0;

  assign full = q_full;

  alcs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .cmd       (in_command),
    .red       (in_red_in),
    .green     (in_green_in),
    .blue      (in_blue_in),
    .alpha     (in_alpha_in),
    .frame_end (in_frame_end),
    .limit     (limit_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wr_data)
  );

  alcs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  alcs_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_rd_data),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  assign out_red_out       = res.rgb[alcs_pkg::ChRed];
  assign out_green_out     = res.rgb[alcs_pkg::ChGreen];
  assign out_blue_out      = res.rgb[alcs_pkg::ChBlue];
  assign out_alpha_out     = res.alpha;
  assign out_was_stretched = res.stretched;

endmodule

[hw/rtl/alcs_front.sv]
// Front end: accepts pixels, tracks gray min/max in the measure pass and
// latches the statistics; apply pixels are tagged and handed to the queue.
// Depends on alcs_pkg.
module alcs_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic                          cmd,
  input  logic [alcs_pkg::PixW-1:0]     red,
  input  logic [alcs_pkg::PixW-1:0]     green,
  input  logic [alcs_pkg::PixW-1:0]     blue,
  input  logic [alcs_pkg::PixW-1:0]     alpha,
  input  logic                          frame_end,
  input  logic [alcs_pkg::LimitW-1:0]   limit,
  input  logic                          q_full,
  output logic                          q_push,
  output alcs_pkg::entry_t              q_data
);

  logic [alcs_pkg::PixW-1:0]     run_min_r, run_min_nxt;
  logic [alcs_pkg::PixW-1:0]     run_max_r, run_max_nxt;
  logic [alcs_pkg::PixW-1:0]     lo_r, lo_nxt;
  logic [alcs_pkg::PixW-1:0]     range_r, range_nxt;
  logic                          armed_r, armed_nxt;
  logic [alcs_pkg::GrayAccW-1:0] gray_acc;
  logic [alcs_pkg::PixW-1:0]     gray;
  logic [alcs_pkg::PixW-1:0]     min_new, max_new, range_new;
  logic                          accept;

  assign accept   = push && !q_full;
  assign gray_acc = alcs_pkg::GrayAccW'(red)   * alcs_pkg::GrayAccW'(11)
                  + alcs_pkg::GrayAccW'(green) * alcs_pkg::GrayAccW'(16)
                  + alcs_pkg::GrayAccW'(blue)  * alcs_pkg::GrayAccW'(5);
  assign gray      = gray_acc[alcs_pkg::GrayAccW-1 -: alcs_pkg::PixW];
  assign min_new   = (gray < run_min_r) ? gray : run_min_r;
  assign max_new   = (gray > run_max_r) ? gray : run_max_r;
  assign range_new = max_new - min_new;

  always_comb begin
    run_min_nxt = run_min_r;
    run_max_nxt = run_max_r;
    lo_nxt      = lo_r;
    range_nxt   = range_r;
    armed_nxt   = armed_r;
    if (accept && cmd == alcs_pkg::CMD_MEASURE) begin
      if (frame_end) begin
        lo_nxt      = min_new;
        range_nxt   = range_new;
        armed_nxt   = (range_new != '0) &&
                      (alcs_pkg::LimitW'(range_new) < limit);
        run_min_nxt = alcs_pkg::MaxLevel;
        run_max_nxt = alcs_pkg::MinLevel;
      end else begin
        run_min_nxt = min_new;
        run_max_nxt = max_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_min_r <= alcs_pkg::MaxLevel;
      run_max_r <= alcs_pkg::MinLevel;
      lo_r      <= '0;
      range_r   <= '0;
      armed_r   <= 1'b0;
    end else begin
      run_min_r <= run_min_nxt;
      run_max_r <= run_max_nxt;
      lo_r      <= lo_nxt;
      range_r   <= range_nxt;
      armed_r   <= armed_nxt;
    end
  end

  // apply pixels carry the statistics in force when they arrive
  assign q_push = accept && (cmd == alcs_pkg::CMD_APPLY);

  always_comb begin
    q_data                           = '0;
    q_data.armed                     = armed_r;
    q_data.lo                        = lo_r;
    q_data.range                     = range_r;
    q_data.rgb[alcs_pkg::ChRed]      = red;
    q_data.rgb[alcs_pkg::ChGreen]    = green;
    q_data.rgb[alcs_pkg::ChBlue]     = blue;
    q_data.alpha                     = alpha;
  end

endmodule

[hw/rtl/alcs_queue.sv]
// Short FIFO of tagged apply pixels between front and back end.
// Depends on alcs_pkg.
module alcs_queue #(
  parameter int Depth = alcs_pkg::QueueDepthDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  alcs_pkg::entry_t  wr_data,
  input  logic              rd_en,
  output alcs_pkg::entry_t  rd_data,
  output logic              full,
  output logic              empty
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  alcs_pkg::entry_t    slots_r [Depth];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]     count_r, count_nxt;
  logic                do_wr, do_rd;

  assign full    = (count_r == CntW'(Depth));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[hw/rtl/alcs_back.sv]
// Back end: takes tagged pixels from the queue; when armed it stretches
// each channel with three restoring dividers (one quotient bit per cycle),
// and the result is registered for the output channel. Depends on alcs_pkg.
module alcs_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  alcs_pkg::entry_t  q_data,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output alcs_pkg::result_t res
);

  localparam int PW = alcs_pkg::PixW;
  localparam int NC = alcs_pkg::NumChan;
  localparam int NW = alcs_pkg::NumW;
  localparam int SW = alcs_pkg::StepCntW;

  alcs_pkg::back_state_t      state_r, state_nxt;
  logic [SW-1:0]              cnt_r, cnt_nxt;
  logic [PW-1:0]              alpha_r, alpha_nxt;
  logic                       armed_r, armed_nxt;
  logic [PW-1:0]              range_r, range_nxt;
  logic [NC-1:0][PW-1:0]      rem_r, rem_nxt;
  logic [NC-1:0][PW-1:0]      nlo_r, nlo_nxt;
  logic [NC-1:0][PW-1:0]      quo_r, quo_nxt;
  logic [NC-1:0]              sat_r, sat_nxt;
  logic                       out_valid_r, out_valid_nxt;
  alcs_pkg::result_t          res_r, res_nxt;
  logic                       load_out;

  logic [NC-1:0][PW-1:0]      diff;
  logic [NC-1:0][NW-1:0]      num;
  logic [NC-1:0][PW:0]        rem2;
  logic [NC-1:0][PW:0]        rem_sub;
  logic [NC-1:0]              ge;
  logic [NC-1:0][PW-1:0]      rem_step;

  // numerator (c - min) * 255, zero when c is at or below the minimum
  always_comb begin
    for (int i = 0; i < NC; i++) begin
      diff[i] = (q_data.rgb[i] > q_data.lo) ? q_data.rgb[i] - q_data.lo : '0;
      num[i]  = {diff[i], {PW{1'b0}}} - NW'(diff[i]);
    end
  end

  // one restoring division step per lane
  always_comb begin
    for (int i = 0; i < NC; i++) begin
      rem2[i]     = {rem_r[i], nlo_r[i][PW-1]};
      rem_sub[i]  = rem2[i] - {1'b0, range_r};
      ge[i]       = (rem2[i] >= {1'b0, range_r});
      rem_step[i] = ge[i] ? rem_sub[i][PW-1:0] : rem2[i][PW-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    alpha_nxt = alpha_r;
    armed_nxt = armed_r;
    range_nxt = range_r;
    rem_nxt   = rem_r;
    nlo_nxt   = nlo_r;
    quo_nxt   = quo_r;
    sat_nxt   = sat_r;
    q_pop     = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      alcs_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          alpha_nxt = q_data.alpha;
          armed_nxt = q_data.armed;
          range_nxt = q_data.range;
          cnt_nxt   = SW'(alcs_pkg::DivSteps - 1);
          for (int i = 0; i < NC; i++) begin
            // quotient above 255 exactly when the upper half reaches the range
            rem_nxt[i] = num[i][NW-1:PW];
            nlo_nxt[i] = num[i][PW-1:0];
            sat_nxt[i] = q_data.armed && (num[i][NW-1:PW] >= q_data.range);
            quo_nxt[i] = q_data.rgb[i];
          end
          state_nxt = q_data.armed ? alcs_pkg::ST_DIV : alcs_pkg::ST_DONE;
        end
      end
      alcs_pkg::ST_DIV: begin
        for (int i = 0; i < NC; i++) begin
          rem_nxt[i] = rem_step[i];
          nlo_nxt[i] = {nlo_r[i][PW-2:0], 1'b0};
          quo_nxt[i] = {quo_r[i][PW-2:0], ge[i]};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = alcs_pkg::ST_DONE;
        end
      end
      alcs_pkg::ST_DONE: begin
        if (!out_valid_r || pop) begin
          load_out  = 1'b1;
          state_nxt = alcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = alcs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_nxt           = res_r;
    out_valid_nxt     = out_valid_r && !pop;
    if (load_out) begin
      for (int i = 0; i < NC; i++) begin
        res_nxt.rgb[i] = sat_r[i] ? alcs_pkg::MaxLevel : quo_r[i];
      end
      res_nxt.alpha     = alpha_r;
      res_nxt.stretched = armed_r;
      out_valid_nxt     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= alcs_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    alpha_r <= alpha_nxt;
    armed_r <= armed_nxt;
    range_r <= range_nxt;
    rem_r   <= rem_nxt;
    nlo_r   <= nlo_nxt;
    quo_r   <= quo_nxt;
    sat_r   <= sat_nxt;
    res_r   <= res_nxt;
  end

  assign empty = !out_valid_r;
  assign res   = res_r;

endmodule

[hw/rtl/alcs_checker.sv]
// Port-level checks for auto_levels_contrast_stretch, attached with bind.
// Depends on alcs_pkg.
module alcs_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            full,
  input  logic                            empty,
  input  logic                            pop,
  input  logic [alcs_pkg::PixW-1:0]       out_red_out,
  input  logic [alcs_pkg::PixW-1:0]       out_green_out,
  input  logic [alcs_pkg::PixW-1:0]       out_blue_out,
  input  logic [alcs_pkg::PixW-1:0]       out_alpha_out,
  input  logic                            out_was_stretched,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [alcs_pkg::CfgAddrW-1:0]   paddr,
  input  logic [alcs_pkg::CfgDataW-1:0]   pwdata,
  input  logic [alcs_pkg::CfgDataW-1:0]   prdata,
  input  logic                            pready
);

  localparam int LW = alcs_pkg::LimitW;

  // reset drops any pending result and frees the queue
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty && !full)
    else $error("result or queue not cleared by reset");

  // reset restores the contrast limit
  a_reset_limit: assert property (@(posedge clk)
    !rst_n |=> (paddr != alcs_pkg::RegLimitAddr) || (prdata[LW-1:0] == alcs_pkg::LimitReset))
    else $error("limit register not restored by reset");

  // a completed write to the limit register reads back next cycle
  a_limit_write: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready && (paddr == alcs_pkg::RegLimitAddr)
    |=> (paddr != alcs_pkg::RegLimitAddr) || (prdata[LW-1:0] == $past(pwdata[LW-1:0])))
    else $error("limit register write lost");

  // a result not taken holds
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_red_out) && $stable(out_green_out)
      && $stable(out_blue_out) && $stable(out_alpha_out) && $stable(out_was_stretched))
    else $error("pending result changed before pop");

endmodule

bind auto_levels_contrast_stretch alcs_checker u_alcs_checker (.*);

[sim/alcs_levels_checker.sv]
// Checker for auto_levels_contrast_stretch: tracks gray statistics, predicts each apply pixel
// and compares the popped results in order. Watches the block's ports only.
// Depends on alcs_pkg for field widths, the command enum and the result struct.
module alcs_levels_checker
  import alcs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic                full,
  input  logic                in_command,
  input  logic [PixW-1:0]     in_red_in,
  input  logic [PixW-1:0]     in_green_in,
  input  logic [PixW-1:0]     in_blue_in,
  input  logic [PixW-1:0]     in_alpha_in,
  input  logic                in_frame_end,
  input  logic                empty,
  input  logic                pop,
  input  logic [PixW-1:0]     out_red_out,
  input  logic [PixW-1:0]     out_green_out,
  input  logic [PixW-1:0]     out_blue_out,
  input  logic [PixW-1:0]     out_alpha_out,
  input  logic                out_was_stretched,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  input  logic                pready,
  output int                  fail_count,
  output int                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [PixW-1:0]   gray_lo;
  logic [PixW-1:0]   gray_hi;
  logic [PixW-1:0]   level_floor;
  logic [PixW-1:0]   level_span;
  logic              stretch_on;
  logic [LimitW-1:0] contrast_limit;
  result_t           pending_pixels[$];
  int                mismatches;

  initial begin
    fail_count  = 0;
    outstanding = 0;
    mismatches  = 0;
  end

  function automatic logic [PixW-1:0] stretch_level(input logic [PixW-1:0] c);
    logic [NumW-1:0] num;
    logic [NumW-1:0] quot;
    if (c <= level_floor || level_span == MinLevel) return MinLevel;
    num  = NumW'(c - level_floor) * NumW'(MaxLevel);
    quot = num / NumW'(level_span);
    return (quot > NumW'(MaxLevel)) ? MaxLevel : quot[PixW-1:0];
  endfunction

  // gray = (11r + 16g + 5b) / 32, truncated
  function automatic void measure_pixel(input logic [PixW-1:0] r, input logic [PixW-1:0] g,
                                        input logic [PixW-1:0] b, input logic last);
    logic [GrayAccW-1:0] acc;
    logic [PixW-1:0]     gray;
    logic [PixW-1:0]     span;
    acc  = GrayAccW'(r) * GrayAccW'(11) + GrayAccW'(g) * GrayAccW'(16)
         + GrayAccW'(b) * GrayAccW'(5);
    gray = acc[GrayAccW-1:5];
    if (gray < gray_lo) gray_lo = gray;
    if (gray > gray_hi) gray_hi = gray;
    if (last) begin
      span        = gray_hi - gray_lo;
      level_floor = gray_lo;
      level_span  = span;
      stretch_on  = (span != MinLevel) && ({1'b0, span} < contrast_limit);
      gray_lo     = MaxLevel;
      gray_hi     = MinLevel;
    end
  endfunction

  function automatic result_t stretch_pixel(input logic [PixW-1:0] r, input logic [PixW-1:0] g,
                                            input logic [PixW-1:0] b, input logic [PixW-1:0] a);
    result_t res;
    if (stretch_on) begin
      res.rgb[ChRed]   = stretch_level(r);
      res.rgb[ChGreen] = stretch_level(g);
      res.rgb[ChBlue]  = stretch_level(b);
      res.stretched    = 1'b1;
    end else begin
      res.rgb[ChRed]   = r;
      res.rgb[ChGreen] = g;
      res.rgb[ChBlue]  = b;
      res.stretched    = 1'b0;
    end
    res.alpha = a;
    return res;
  endfunction

  function automatic void report_pixel(input string what, input result_t exp_px);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: exp r=%0d g=%0d b=%0d a=%0d st=%0d, got r=%0d g=%0d b=%0d a=%0d st=%0d",
               $realtime, what, exp_px.rgb[ChRed], exp_px.rgb[ChGreen], exp_px.rgb[ChBlue],
               exp_px.alpha, exp_px.stretched, out_red_out, out_green_out, out_blue_out,
               out_alpha_out, out_was_stretched);
  endfunction

  always @(posedge clk) begin
    result_t exp_px;
    if (!rst_n) begin
      gray_lo        = MaxLevel;
      gray_hi        = MinLevel;
      level_floor    = MinLevel;
      level_span     = MinLevel;
      stretch_on     = 1'b0;
      contrast_limit = LimitReset;
      pending_pixels.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == RegLimitAddr)
        contrast_limit = pwdata[LimitW-1:0];
      if (pop && !empty) begin
        if (pending_pixels.size() == 0) begin
          exp_px = '0;
          report_pixel("unexpected pixel", exp_px);
        end else begin
          exp_px = pending_pixels.pop_front();
          if (out_red_out != exp_px.rgb[ChRed] || out_green_out != exp_px.rgb[ChGreen] ||
              out_blue_out != exp_px.rgb[ChBlue] || out_alpha_out != exp_px.alpha ||
              out_was_stretched != exp_px.stretched)
            report_pixel("pixel mismatch", exp_px);
        end
      end
      if (push && !full) begin
        if (cmd_t'(in_command) == CMD_MEASURE)
          measure_pixel(in_red_in, in_green_in, in_blue_in, in_frame_end);
        else
          pending_pixels.push_back(stretch_pixel(in_red_in, in_green_in, in_blue_in,
                                                 in_alpha_in));
      end
    end
    outstanding <= pending_pixels.size();
    fail_count  <= mismatches;
  end

endmodule

[sim/tb_auto_levels_contrast_stretch.sv]
// Top testbench for auto_levels_contrast_stretch: drives measure/apply pixel streams and
// limit register writes, with bursty input and a stalling consumer. Needs alcs_pkg, the
// block and alcs_levels_checker, which does all prediction and comparison.
module tb_auto_levels_contrast_stretch;
  timeunit 1ns;
  timeprecision 1ps;
  import alcs_pkg::*;

  localparam int ItemTarget     = 1950;
  localparam int PhaseItems     = 220;
  localparam int SettleCycles   = 40;
  localparam int HoldCycles     = 300;
  localparam int WatchdogLimit  = 4000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                push = 1'b0;
  logic                full;
  logic                in_command = CMD_MEASURE;
  logic [PixW-1:0]     in_red_in = '0;
  logic [PixW-1:0]     in_green_in = '0;
  logic [PixW-1:0]     in_blue_in = '0;
  logic [PixW-1:0]     in_alpha_in = '0;
  logic                in_frame_end = 1'b0;
  logic                empty;
  logic                pop = 1'b0;
  logic [PixW-1:0]     out_red_out;
  logic [PixW-1:0]     out_green_out;
  logic [PixW-1:0]     out_blue_out;
  logic [PixW-1:0]     out_alpha_out;
  logic                out_was_stretched;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;
  int                  fail_count;
  int                  outstanding;

  int items_sent = 0;
  int burst_left = 0;
  int gap_max = 3;
  int quiet_cycles = 0;
  int pops_seen = 0;
  int hold_left = 0;
  int holds_done = 0;
  int rx_cycle = 0;

  auto_levels_contrast_stretch dut (.*);

  alcs_levels_checker levels_check (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // consumer: rotating stall pattern plus two long hold-offs to back up the queue
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) pops_seen++;
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if ((holds_done == 0 && pops_seen >= 150) ||
                   (holds_done == 1 && pops_seen >= 700)) begin
        holds_done++;
        hold_left = HoldCycles;
        pop <= 1'b0;
      end else begin
        case (rx_cycle[9:8])
          2'd0: pop <= 1'b1;
          2'd1: pop <= 1'($urandom_range(0, 1));
          2'd2: pop <= ($urandom_range(0, 3) == 0);
          default: pop <= (rx_cycle % 5 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic offer_pixel(input cmd_t cmd, input logic [PixW-1:0] r,
                             input logic [PixW-1:0] g, input logic [PixW-1:0] b,
                             input logic [PixW-1:0] a, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, gap_max);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    push         <= 1'b1;
    in_command   <= cmd;
    in_red_in    <= r;
    in_green_in  <= g;
    in_blue_in   <= b;
    in_alpha_in  <= a;
    in_frame_end <= last;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  // drop push, wait out every expected pixel, then let trailing measures drain
  task automatic settle_block();
    push <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LimitW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegLimitAddr;
    pwdata  <= CfgDataW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [LimitW-1:0] planned_limit(input int phase);
    case (phase)
      0: return 9'd256;
      1: return 9'd1;
      2: return 9'd0;
      3: return 9'd511;
      4: return 9'd2;
      5: return 9'd255;
      6: return LimitReset;
      default: return LimitW'($urandom_range(1, 256));
    endcase
  endfunction

  function automatic logic [PixW-1:0] near_level(input int base, input int spread);
    int v;
    v = base - spread / 4 + $urandom_range(0, spread);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return PixW'(v);
  endfunction

  function automatic logic [PixW-1:0] any_level();
    return PixW'($urandom_range(0, 255));
  endfunction

  // one measure pass closed by frame_end, then a run of apply pixels
  task automatic run_frame();
    int npix;
    int napply;
    int base;
    int spread;
    int i;
    npix = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 30) : $urandom_range(1, 5);
    base = $urandom_range(0, 255);
    case ($urandom_range(0, 4))
      0: spread = 0;
      1: spread = $urandom_range(0, 255);
      default: spread = $urandom_range(1, 40);
    endcase
    for (i = 0; i < npix; i++)
      offer_pixel(CMD_MEASURE, near_level(base, spread), near_level(base, spread),
                  near_level(base, spread), any_level(), i == npix - 1);
    napply = $urandom_range(1, 8);
    for (i = 0; i < napply; i++) begin
      if ($urandom_range(0, 1) == 0)
        offer_pixel(CMD_APPLY, near_level(base, spread), near_level(base, spread),
                    near_level(base, spread), any_level(), 1'($urandom_range(0, 1)));
      else
        offer_pixel(CMD_APPLY, any_level(), any_level(), any_level(), any_level(),
                    1'($urandom_range(0, 1)));
    end
  endtask

  initial begin : stimulus
    int phase;
    int phase_start;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // apply before any frame end, and frame_end on an apply pixel
    offer_pixel(CMD_APPLY, 8'd255, 8'd0, 8'd128, 8'd77, 1'b0);
    offer_pixel(CMD_APPLY, 8'd0, 8'd255, 8'd1, 8'd128, 1'b1);
    // flat frame leaves stretching off
    offer_pixel(CMD_MEASURE, 8'd50, 8'd50, 8'd50, 8'd0, 1'b1);
    offer_pixel(CMD_APPLY, 8'd200, 8'd10, 8'd50, 8'd255, 1'b0);
    // range 60 from zero: stretch, including clamp at the top
    offer_pixel(CMD_MEASURE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    offer_pixel(CMD_MEASURE, 8'd60, 8'd60, 8'd60, 8'd255, 1'b1);
    offer_pixel(CMD_APPLY, 8'd0, 8'd30, 8'd60, 8'd255, 1'b0);
    offer_pixel(CMD_APPLY, 8'd255, 8'd255, 8'd255, 8'd0, 1'b0);
    // floor at 100: channels at or below the floor go to zero
    offer_pixel(CMD_MEASURE, 8'd100, 8'd100, 8'd100, 8'd1, 1'b0);
    offer_pixel(CMD_MEASURE, 8'd150, 8'd150, 8'd150, 8'd2, 1'b1);
    offer_pixel(CMD_APPLY, 8'd50, 8'd100, 8'd200, 8'd170, 1'b0);
    offer_pixel(CMD_APPLY, 8'd101, 8'd125, 8'd149, 8'd85, 1'b0);
    // full range is above the limit: pass through
    offer_pixel(CMD_MEASURE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    offer_pixel(CMD_MEASURE, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    offer_pixel(CMD_APPLY, 8'd17, 8'd34, 8'd51, 8'd68, 1'b0);
    // weighted gray of pure red and pure green
    offer_pixel(CMD_MEASURE, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0);
    offer_pixel(CMD_MEASURE, 8'd0, 8'd255, 8'd0, 8'd0, 1'b1);
    offer_pixel(CMD_APPLY, 8'd255, 8'd255, 8'd0, 8'd1, 1'b0);

    phase = 0;
    while (items_sent < ItemTarget) begin
      settle_block();
      write_limit(planned_limit(phase));
      case (phase % 3)
        0: gap_max = 3;
        1: gap_max = 0;
        default: gap_max = 8;
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems && items_sent < ItemTarget) begin
        if ($urandom_range(0, 9) != 0)
          run_frame();
        else
          offer_pixel(cmd_t'($urandom_range(0, 1)), any_level(), any_level(), any_level(),
                      any_level(), $urandom_range(0, 7) == 0);
      end
      phase++;
    end

    settle_block();
    if (fail_count == 0 && outstanding == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

[files.f]
hw/rtl/alcs_pkg.sv
hw/rtl/alcs_front.sv
hw/rtl/alcs_queue.sv
hw/rtl/alcs_back.sv
hw/rtl/auto_levels_contrast_stretch.sv
hw/rtl/alcs_checker.sv
sim/alcs_levels_checker.sv
sim/tb_auto_levels_contrast_stretch.sv
